// ===== rtl/core/btim_pkg.sv =====
// shared types, widths and codes of the baseline triangular index map
package btim_pkg;

   localparam int MAX_ANTENNAS = 4096;

   localparam int ANT_W      = 13;
   localparam int IDX_W      = 26;
   localparam int POL_IN_W   = 3;
   localparam int POL_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_W      = 8;
   localparam int CSR_IDX_W  = 1;

   // root of 8k+1 is taken two radicand bits per cell
   localparam int ROOT_STEPS = (IDX_W + 4) / 2;
   localparam int RAD_W      = 2 * ROOT_STEPS;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int REM_W      = ROOT_W + 2;
   localparam int COMP_W     = ROOT_W - 1;
   localparam int PROD_W     = 2 * COMP_W + 1;
   localparam int TRI_W      = 2 * COMP_W;

   localparam logic [POL_IN_W-1:0] POL_PAIR_MAX = POL_IN_W'(3);

   // number of products for 2*MAX_ANTENNAS composite inputs
   localparam longint unsigned TRI_LIMIT =
      64'(MAX_ANTENNAS) * 64'(2 * MAX_ANTENNAS + 1);

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ANTENNA_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCT_BASE = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ANT   = 2'd1,
      ST_BAD_POL   = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // one transaction as it moves down the chain
   typedef struct packed {
      logic                valid;
      logic                cmd;
      status_type          status;
      logic [COMP_W-1:0]   c1;
      logic [COMP_W-1:0]   c2;
      logic [IDX_W-1:0]    k;
      logic [RAD_W-1:0]    rad;
      logic [REM_W-1:0]    rem;
      logic [ROOT_W-1:0]   root;
      logic [PROD_W-1:0]   prod;
   } item_type;

   typedef struct packed {
      logic                valid;
      logic [IDX_W-1:0]    index;
      logic [ANT_W-1:0]    ant_first;
      logic [ANT_W-1:0]    ant_second;
      logic [POL_W-1:0]    pol_pair;
      status_type          status;
   } result_type;

endpackage

// ===== rtl/core/btim_entry.sv =====
// entry stage: range checks, composite indices and root radicand
module btim_entry import btim_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   input  logic [ANT_W-1:0]      req_ant_first,
   input  logic [ANT_W-1:0]      req_ant_second,
   input  logic [POL_IN_W-1:0]   req_pol_pair,
   input  logic [IDX_W-1:0]      req_product_index,
   input  logic [CSR_W-1:0]      antenna_base,
   input  logic [CSR_W-1:0]      product_base,
   input  logic                  ready_dn,
   output logic                  ready_up,
   output item_type              item_dn
);

   item_type          item_ff;
   item_type          item_in;
   logic [ANT_W-1:0]  base_ext;
   logic [ANT_W-1:0]  d1;
   logic [ANT_W-1:0]  d2;
   logic              ant_ok;
   logic [IDX_W-1:0]  pbase_ext;
   logic [IDX_W-1:0]  k;
   logic              k_ok;

   assign ready_up = !item_ff.valid || ready_dn;
   assign item_dn  = item_ff;

   always_comb begin
      base_ext  = ANT_W'(antenna_base);
      d1        = req_ant_first - base_ext;
      d2        = req_ant_second - base_ext;
      ant_ok    = (req_ant_first >= base_ext) && (req_ant_second >= base_ext) &&
                  (32'(d1) < 32'(MAX_ANTENNAS)) && (32'(d2) < 32'(MAX_ANTENNAS));
      pbase_ext = IDX_W'(product_base);
      k         = req_product_index - pbase_ext;
      k_ok      = (req_product_index >= pbase_ext) && (64'(k) < TRI_LIMIT);

      item_in       = '0;
      item_in.valid = req_valid;
      item_in.cmd   = req_cmd;
      item_in.c1    = COMP_W'({d1, req_pol_pair[1]});
      item_in.c2    = COMP_W'({d2, req_pol_pair[0]});
      item_in.k     = k;
      item_in.rad   = RAD_W'({k, 3'b001});
      if (req_cmd == CMD_DECODE) begin
         item_in.status = k_ok ? ST_OK : ST_BAD_INDEX;
      end else if (!ant_ok) begin
         item_in.status = ST_BAD_ANT;
      end else if (req_pol_pair > POL_PAIR_MAX) begin
         item_in.status = ST_BAD_POL;
      end else begin
         item_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (ready_up) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/core/btim_root_cell.sv =====
// one cell of the square root chain: one result bit per cell
module btim_root_cell import btim_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  item_type  item_up,
   input  logic      ready_dn,
   output logic      ready_up,
   output item_type  item_dn
);

   item_type            item_ff;
   item_type            item_in;
   logic [REM_W+1:0]    cur;
   logic [REM_W+1:0]    trial;

   assign ready_up = !item_ff.valid || ready_dn;
   assign item_dn  = item_ff;

   always_comb begin
      // bring down the next two radicand bits, try root*4+1
      cur     = {item_up.rem, item_up.rad[RAD_W-1 -: 2]};
      trial   = (REM_W + 2)'({item_up.root, 2'b01});
      item_in = item_up;
      item_in.rad = {item_up.rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         item_in.rem  = REM_W'(cur - trial);
         item_in.root = {item_up.root[ROOT_W-2:0], 1'b1};
      end else begin
         item_in.rem  = REM_W'(cur);
         item_in.root = {item_up.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (ready_up) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/core/btim_tri_stage.sv =====
// takes c2 from the root on decode or from the request on encode, forms c2*(c2+1)
module btim_tri_stage import btim_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  item_type  item_up,
   input  logic      ready_dn,
   output logic      ready_up,
   output item_type  item_dn
);

   item_type            item_ff;
   item_type            item_in;
   logic [ROOT_W-1:0]   root_dec;
   logic [COMP_W-1:0]   c2_sel;
   logic [COMP_W:0]     c2_inc;

   assign ready_up = !item_ff.valid || ready_dn;
   assign item_dn  = item_ff;

   always_comb begin
      // decode: c2 = (root - 1) / 2
      root_dec = item_up.root - ROOT_W'(1);
      c2_sel   = (item_up.cmd == CMD_DECODE) ? COMP_W'(root_dec >> 1) : item_up.c2;
      c2_inc   = {1'b0, c2_sel} + (COMP_W + 1)'(1);
      item_in      = item_up;
      item_in.c2   = c2_sel;
      item_in.prod = PROD_W'(c2_sel) * PROD_W'(c2_inc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (ready_up) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/core/btim_out_stage.sv =====
// final stage: index sum or antenna recovery, output register
module btim_out_stage import btim_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  item_type            item_up,
   input  logic [CSR_W-1:0]    antenna_base,
   input  logic [CSR_W-1:0]    product_base,
   input  logic                rsp_stall,
   output logic                ready_up,
   output logic                rsp_valid,
   output logic [IDX_W-1:0]    rsp_out_index,
   output logic [ANT_W-1:0]    rsp_out_ant_first,
   output logic [ANT_W-1:0]    rsp_out_ant_second,
   output logic [POL_W-1:0]    rsp_out_pol_pair,
   output logic [STATUS_W-1:0] rsp_status
);

   result_type          res_ff;
   result_type          res_in;
   logic [TRI_W-1:0]    tri_val;
   logic [COMP_W-1:0]   c1_dec;
   logic [ANT_W-1:0]    base_ext;

   assign ready_up = !res_ff.valid || !rsp_stall;

   always_comb begin
      tri_val  = TRI_W'(item_up.prod >> 1);
      c1_dec   = COMP_W'(TRI_W'(item_up.k) - tri_val);
      base_ext = ANT_W'(antenna_base);

      res_in        = '0;
      res_in.valid  = item_up.valid;
      res_in.status = item_up.status;
      if (item_up.status == ST_OK) begin
         if (item_up.cmd == CMD_ENCODE) begin
            res_in.index = IDX_W'(TRI_W'(item_up.c1) + tri_val + TRI_W'(product_base));
         end else begin
            res_in.ant_first  = ANT_W'(c1_dec >> 1) + base_ext;
            res_in.ant_second = ANT_W'(item_up.c2 >> 1) + base_ext;
            res_in.pol_pair   = {c1_dec[0], item_up.c2[0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (ready_up) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid          = res_ff.valid;
   assign rsp_out_index      = res_ff.index;
   assign rsp_out_ant_first  = res_ff.ant_first;
   assign rsp_out_ant_second = res_ff.ant_second;
   assign rsp_out_pol_pair   = res_ff.pol_pair;
   assign rsp_status         = STATUS_W'(res_ff.status);

endmodule

// ===== rtl/core/baseline_triangular_index_map_top.sv =====
// top level of the baseline triangular index map
//
// Maps correlation products both ways. A request with cmd encode carries two
// antennas and a polarization pair and returns the product index; with cmd
// decode it carries a product index and returns antennas and pair. Every
// request gives exactly one response, in order, with a status code.
//
// Channels: req_* in, rsp_* out, valid/stall handshake; a transaction moves
// at a clock edge with valid high and stall low. csr_wen writes
// csr_wdata into register csr_index (0 antenna base, 1 product base).
//
// Stages in order: entry stage, 15 square root cells (one root bit each),
// the c2*(c2+1) multiplier stage and the output register. Throughput is
// one transaction per cycle while rsp_stall is low; every stage advances
// on its own, so bubbles close up and a request is taken while a response
// waits, as long as some stage is empty.
//
// Synchronous reset empties the pipeline and clears both registers to zero.
// A stalled response holds; req_stall rises only when every stage is full.
module baseline_triangular_index_map_top import btim_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [ANT_W-1:0]     req_ant_first,
   input  logic [ANT_W-1:0]     req_ant_second,
   input  logic [POL_IN_W-1:0]  req_pol_pair,
   input  logic [IDX_W-1:0]     req_product_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_out_index,
   output logic [ANT_W-1:0]     rsp_out_ant_first,
   output logic [ANT_W-1:0]     rsp_out_ant_second,
   output logic [POL_W-1:0]     rsp_out_pol_pair,
   output logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [CSR_W-1:0]   antenna_base_ff;
   logic [CSR_W-1:0]   antenna_base_in;
   logic [CSR_W-1:0]   product_base_ff;
   logic [CSR_W-1:0]   product_base_in;

   item_type           root_item [0:ROOT_STEPS];
   logic [ROOT_STEPS:0] root_ready;
   logic               entry_ready;
   item_type           tri_item;
   logic               out_ready;

   always_comb begin
      antenna_base_in = antenna_base_ff;
      product_base_in = product_base_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ANTENNA_BASE: antenna_base_in = csr_wdata;
            CSR_PRODUCT_BASE: product_base_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         antenna_base_ff <= '0;
         product_base_ff <= '0;
      end else begin
         antenna_base_ff <= antenna_base_in;
         product_base_ff <= product_base_in;
      end
   end

   assign req_stall = !entry_ready;

   btim_entry u_entry (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_cmd           (req_cmd),
      .req_ant_first     (req_ant_first),
      .req_ant_second    (req_ant_second),
      .req_pol_pair      (req_pol_pair),
      .req_product_index (req_product_index),
      .antenna_base      (antenna_base_ff),
      .product_base      (product_base_ff),
      .ready_dn          (root_ready[0]),
      .ready_up          (entry_ready),
      .item_dn           (root_item[0])
   );

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      btim_root_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .item_up  (root_item[i]),
         .ready_dn (root_ready[i+1]),
         .ready_up (root_ready[i]),
         .item_dn  (root_item[i+1])
      );
   end

   btim_tri_stage u_tri (
      .clock    (clock),
      .reset    (reset),
      .item_up  (root_item[ROOT_STEPS]),
      .ready_dn (out_ready),
      .ready_up (root_ready[ROOT_STEPS]),
      .item_dn  (tri_item)
   );

   btim_out_stage u_out (
      .clock              (clock),
      .reset              (reset),
      .item_up            (tri_item),
      .antenna_base       (antenna_base_ff),
      .product_base       (product_base_ff),
      .rsp_stall          (rsp_stall),
      .ready_up           (out_ready),
      .rsp_valid          (rsp_valid),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_ant_first  (rsp_out_ant_first),
      .rsp_out_ant_second (rsp_out_ant_second),
      .rsp_out_pol_pair   (rsp_out_pol_pair),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== rtl/core/btim_checker.sv =====
// port-level checks of the baseline triangular index map, bound to the top
module btim_checker import btim_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [ANT_W-1:0]     req_ant_first,
   input  logic [ANT_W-1:0]     req_ant_second,
   input  logic [POL_IN_W-1:0]  req_pol_pair,
   input  logic [IDX_W-1:0]     req_product_index,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [IDX_W-1:0]     rsp_out_index,
   input  logic [ANT_W-1:0]     rsp_out_ant_first,
   input  logic [ANT_W-1:0]     rsp_out_ant_second,
   input  logic [POL_W-1:0]     rsp_out_pol_pair,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_index) &&
      $stable(rsp_out_ant_first) && $stable(rsp_out_ant_second) &&
      $stable(rsp_out_pol_pair) && $stable(rsp_status))
      else $error("stalled response changed");

   // request side only backs up when the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with output free");

   // error responses carry nothing but the status
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_W'(ST_OK)) |->
      rsp_out_index == '0 && rsp_out_ant_first == '0 &&
      rsp_out_ant_second == '0 && rsp_out_pol_pair == '0)
      else $error("error response with nonzero fields");

   // an encode result never carries decoded antennas
   a_encode_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_index != '0) |->
      rsp_out_ant_first == '0 && rsp_out_ant_second == '0 && rsp_out_pol_pair == '0)
      else $error("index and antennas both set");

endmodule

bind baseline_triangular_index_map_top btim_checker u_checker (.*);

// ===== bench/tb.sv =====
// self-checking testbench for the baseline triangular index map: encode and decode traffic
`timescale 1ns / 1ps

module tb;
   import btim_pkg::*;

   localparam longint unsigned PRODUCT_COUNT =
      longint'(MAX_ANTENNAS) * longint'(2 * MAX_ANTENNAS + 1);
   localparam int unsigned CYCLE_LIMIT = 500000;

   localparam logic [POL_IN_W-1:0] POL_XX = 3'd0;
   localparam logic [POL_IN_W-1:0] POL_XY = 3'd1;
   localparam logic [POL_IN_W-1:0] POL_YX = 3'd2;
   localparam logic [POL_IN_W-1:0] POL_YY = 3'd3;
   localparam logic [POL_IN_W-1:0] POL_BAD_LO = POL_PAIR_MAX + 3'd1;
   localparam logic [POL_IN_W-1:0] POL_BAD_HI = '1;

   typedef struct {
      logic                cmd;
      logic [ANT_W-1:0]    ant_first;
      logic [ANT_W-1:0]    ant_second;
      logic [POL_IN_W-1:0] pol_pair;
      logic [IDX_W-1:0]    product_index;
   } map_request_type;

   typedef struct {
      logic [IDX_W-1:0]    index;
      logic [ANT_W-1:0]    ant_first;
      logic [ANT_W-1:0]    ant_second;
      logic [POL_W-1:0]    pol_pair;
      status_type          status;
   } map_result_type;

   class baseline_map_checker;
      logic [CSR_W-1:0] ant_base;
      logic [CSR_W-1:0] prod_base;
      map_result_type   pending_maps[$];
      int               mismatches;

      function new();
         ant_base   = '0;
         prod_base  = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         if (idx == CSR_ANTENNA_BASE)
            ant_base = val;
         else if (idx == CSR_PRODUCT_BASE)
            prod_base = val;
      endfunction

      function longint unsigned tri_count(longint unsigned n);
         return (n * n + n) / 2;
      endfunction

      // exact floor of the square root, one root bit at a time
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 20; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
               root = trial;
         end
         return root;
      endfunction

      function map_result_type map_baseline(map_request_type r);
         map_result_type  res;
         longint unsigned a1, a2, ab, pb, c1, c2, k, pidx;
         res.index      = '0;
         res.ant_first  = '0;
         res.ant_second = '0;
         res.pol_pair   = '0;
         res.status     = ST_OK;
         a1   = 64'(r.ant_first);
         a2   = 64'(r.ant_second);
         ab   = 64'(ant_base);
         pb   = 64'(prod_base);
         pidx = 64'(r.product_index);
         if (r.cmd == CMD_ENCODE) begin
            // antenna range is checked before the polarization pair
            if (a1 < ab || a2 < ab || a1 - ab >= MAX_ANTENNAS || a2 - ab >= MAX_ANTENNAS) begin
               res.status = ST_BAD_ANT;
            end else if (r.pol_pair > POL_PAIR_MAX) begin
               res.status = ST_BAD_POL;
            end else begin
               c1 = 2 * (a1 - ab) + (r.pol_pair >> 1);
               c2 = 2 * (a2 - ab) + (r.pol_pair & 1);
               res.index = IDX_W'(c1 + tri_count(c2) + pb);
            end
         end else begin
            if (pidx < pb || pidx - pb >= PRODUCT_COUNT) begin
               res.status = ST_BAD_INDEX;
            end else begin
               k  = pidx - pb;
               c2 = (floor_root(1 + 8 * k) - 1) / 2;
               c1 = k - tri_count(c2);
               res.ant_first  = ANT_W'((c1 >> 1) + ab);
               res.ant_second = ANT_W'((c2 >> 1) + ab);
               res.pol_pair   = POL_W'(2 * (c1 & 1) + (c2 & 1));
            end
         end
         return res;
      endfunction

      function void note_request(map_request_type r);
         pending_maps.push_back(map_baseline(r));
      endfunction

      function int pending_count();
         return pending_maps.size();
      endfunction

      function void check_response(map_result_type got);
         map_result_type want;
         if (pending_maps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response idx %0d ant %0d/%0d pol %0d status %0d",
                        $realtime, got.index, got.ant_first, got.ant_second,
                        got.pol_pair, got.status);
            return;
         end
         want = pending_maps.pop_front();
         if (got.index !== want.index || got.ant_first !== want.ant_first ||
             got.ant_second !== want.ant_second || got.pol_pair !== want.pol_pair ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("%0t: mismatch expected idx %0d ant %0d/%0d pol %0d status %0d, ",
                      $realtime, want.index, want.ant_first, want.ant_second,
                      want.pol_pair, want.status);
               $display("got idx %0d ant %0d/%0d pol %0d status %0d",
                        got.index, got.ant_first, got.ant_second, got.pol_pair,
                        got.status);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_cmd;
   logic [ANT_W-1:0]     req_ant_first;
   logic [ANT_W-1:0]     req_ant_second;
   logic [POL_IN_W-1:0]  req_pol_pair;
   logic [IDX_W-1:0]     req_product_index;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [IDX_W-1:0]     rsp_out_index;
   logic [ANT_W-1:0]     rsp_out_ant_first;
   logic [ANT_W-1:0]     rsp_out_ant_second;
   logic [POL_W-1:0]     rsp_out_pol_pair;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   baseline_map_checker map_check;
   bit                  flood_on = 1'b0;
   bit                  hold_done = 1'b0;
   int unsigned         cycle_count = 0;

   baseline_triangular_index_map_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_ant_first      (req_ant_first),
      .req_ant_second     (req_ant_second),
      .req_pol_pair       (req_pol_pair),
      .req_product_index  (req_product_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_ant_first  (rsp_out_ant_first),
      .rsp_out_ant_second (rsp_out_ant_second),
      .rsp_out_pol_pair   (rsp_out_pol_pair),
      .rsp_status         (rsp_status),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // encode request; the decode field carries noise
   function automatic map_request_type enc_req(logic [ANT_W-1:0] a1, logic [ANT_W-1:0] a2,
                                               logic [POL_IN_W-1:0] q);
      map_request_type r;
      r.cmd           = CMD_ENCODE;
      r.ant_first     = a1;
      r.ant_second    = a2;
      r.pol_pair      = q;
      r.product_index = IDX_W'($urandom);
      return r;
   endfunction

   // decode request; the encode fields carry noise
   function automatic map_request_type dec_req(logic [IDX_W-1:0] p);
      map_request_type r;
      r.cmd           = CMD_DECODE;
      r.ant_first     = ANT_W'($urandom);
      r.ant_second    = ANT_W'($urandom);
      r.pol_pair      = POL_IN_W'($urandom);
      r.product_index = p;
      return r;
   endfunction

   function automatic logic [ANT_W-1:0] rand_ant();
      int unsigned b;
      b = 32'(map_check.ant_base);
      case ($urandom_range(0, 9))
         8: begin
            case ($urandom_range(0, 3))
               0:       return ANT_W'(b);
               1:       return ANT_W'(b + MAX_ANTENNAS - 1);
               2:       return ANT_W'(b - 1);
               default: return ANT_W'(b + MAX_ANTENNAS);
            endcase
         end
         9:       return ANT_W'($urandom);
         default: return ANT_W'(b + $urandom_range(0, MAX_ANTENNAS - 1));
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      longint unsigned pb;
      pb = 64'(map_check.prod_base);
      case ($urandom_range(0, 9))
         7: return IDX_W'(pb + $urandom_range(0, 200));
         8: begin
            case ($urandom_range(0, 3))
               0:       return IDX_W'(pb - 1);
               1:       return IDX_W'(pb + PRODUCT_COUNT - 1);
               2:       return IDX_W'(pb + PRODUCT_COUNT);
               // land on a row boundary, where the root is exact
               default: return IDX_W'(pb + map_check.tri_count($urandom_range(1, 2 * MAX_ANTENNAS))
                                      - $urandom_range(0, 1));
            endcase
         end
         9:       return IDX_W'($urandom);
         default: return IDX_W'(pb + $urandom_range(0, int'(PRODUCT_COUNT - 1)));
      endcase
   endfunction

   function automatic map_request_type rand_request();
      logic [POL_IN_W-1:0] q;
      if ($urandom_range(0, 1) == 0)
         return dec_req(rand_index());
      q = ($urandom_range(0, 6) == 0) ? POL_IN_W'($urandom) : POL_IN_W'($urandom_range(0, 3));
      return enc_req(rand_ant(), rand_ant(), q);
   endfunction

   task automatic offer(input map_request_type r);
      req_valid         <= 1'b1;
      req_cmd           <= r.cmd;
      req_ant_first     <= r.ant_first;
      req_ant_second    <= r.ant_second;
      req_pol_pair      <= r.pol_pair;
      req_product_index <= r.product_index;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      map_check.note_request(r);
   endtask

   task automatic idle(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (map_check.pending_count() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic load_bases(input logic [CSR_W-1:0] ab, input logic [CSR_W-1:0] pb);
      csr_wen   <= 1'b1;
      csr_index <= CSR_ANTENNA_BASE;
      csr_wdata <= ab;
      @(posedge clock);
      map_check.set_register(CSR_ANTENNA_BASE, ab);
      csr_index <= CSR_PRODUCT_BASE;
      csr_wdata <= pb;
      @(posedge clock);
      map_check.set_register(CSR_PRODUCT_BASE, pb);
      csr_wen <= 1'b0;
   endtask

   task automatic run_random(input int count, input bit gaps);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            offer(rand_request());
            burst--;
            count--;
         end
         if (gaps)
            idle($urandom_range(0, 15));
      end
   endtask

   task automatic run_directed();
      map_request_type reqs[$];
      int unsigned     b;
      longint unsigned pb;
      b  = 32'(map_check.ant_base);
      pb = 64'(map_check.prod_base);
      reqs.push_back(enc_req(ANT_W'(b), ANT_W'(b), POL_XX));
      reqs.push_back(enc_req(ANT_W'(b + 4095), ANT_W'(b + 4095), POL_YY));
      // upper triangle: first composite above the second
      reqs.push_back(enc_req(ANT_W'(b + 4095), ANT_W'(b), POL_XY));
      reqs.push_back(enc_req(ANT_W'(b), ANT_W'(b + 4095), POL_YX));
      reqs.push_back(enc_req(ANT_W'(b - 1), ANT_W'(b), POL_XX));
      reqs.push_back(enc_req(ANT_W'(b), ANT_W'(b + MAX_ANTENNAS), POL_XX));
      // bad antenna wins over bad pair
      reqs.push_back(enc_req('1, '1, POL_BAD_HI));
      reqs.push_back(enc_req(ANT_W'(b + 5), ANT_W'(b + 9), POL_BAD_LO));
      reqs.push_back(enc_req(ANT_W'(b + 7), ANT_W'(b + 3), POL_BAD_HI));
      reqs.push_back(enc_req(13'h0aaa, 13'h0555, POL_XY));
      reqs.push_back(enc_req(13'h0555, 13'h0aaa, POL_YX));
      reqs.push_back(dec_req(IDX_W'(pb)));
      reqs.push_back(dec_req(IDX_W'(pb + 1)));
      reqs.push_back(dec_req(IDX_W'(pb + 2)));
      reqs.push_back(dec_req(IDX_W'(pb + 5049)));
      reqs.push_back(dec_req(IDX_W'(pb + 5050)));
      reqs.push_back(dec_req(IDX_W'(pb + map_check.tri_count(8191) - 1)));
      reqs.push_back(dec_req(IDX_W'(pb + map_check.tri_count(8191))));
      reqs.push_back(dec_req(IDX_W'(pb + PRODUCT_COUNT - 1)));
      reqs.push_back(dec_req(IDX_W'(pb + PRODUCT_COUNT)));
      reqs.push_back(dec_req(IDX_W'(pb - 1)));
      reqs.push_back(dec_req('1));
      reqs.push_back(dec_req(26'h1555555));
      reqs.push_back(dec_req(26'h2aaaaaa));
      foreach (reqs[i])
         offer(reqs[i]);
   endtask

   // receiver stall pattern, with one long hold once the flood phase starts
   initial begin : rsp_side
      int mode;
      int len;
      int tick;
      rsp_stall <= 1'b0;
      tick = 0;
      @(posedge clock);
      forever begin
         if (flood_on && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (160) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(8, 80);
            while (len > 0 && !(flood_on && !hold_done)) begin
               case (mode)
                  0, 1, 2: rsp_stall <= 1'b0;
                  3, 4, 5: rsp_stall <= ($urandom_range(0, 3) == 0);
                  6, 7:    rsp_stall <= ($urandom_range(0, 1) == 1);
                  8:       rsp_stall <= (tick % 3 == 0);
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               tick++;
               len--;
               @(posedge clock);
            end
         end
      end
   end

   initial begin : rsp_monitor
      map_result_type got;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.index      = rsp_out_index;
            got.ant_first  = rsp_out_ant_first;
            got.ant_second = rsp_out_ant_second;
            got.pol_pair   = rsp_out_pol_pair;
            got.status     = status_type'(rsp_status);
            map_check.check_response(got);
         end
      end
   end

   initial begin : stimulus
      map_check = new();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= CMD_ENCODE;
      req_ant_first     <= '0;
      req_ant_second    <= '0;
      req_pol_pair      <= POL_XX;
      req_product_index <= '0;
      csr_wen           <= 1'b0;
      csr_index         <= CSR_ANTENNA_BASE;
      csr_wdata         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers still hold their reset values here
      run_directed();
      run_random(200, 1'b1);
      drain();

      load_bases(8'hff, 8'hff);
      run_random(200, 1'b1);
      drain();

      load_bases(8'hff, 8'h00);
      run_random(200, 1'b1);
      drain();

      // back-to-back traffic against a long receiver hold
      load_bases(8'h00, 8'hff);
      flood_on = 1'b1;
      run_random(200, 1'b0);
      drain();

      for (int i = 0; i < 5; i++) begin
         load_bases(CSR_W'($urandom), CSR_W'($urandom));
         run_random(210, i % 2 == 0);
         drain();
      end

      repeat (24) @(posedge clock);
      if (map_check.mismatches == 0 && map_check.pending_count() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
